[rtl/periodic_task_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task scheduler.
// Checks compile in simulation and fall away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must never hold outside reset.
`define PTS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define PTS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define PTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Types, constants and the ordering function of the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Table size and field widths.
	localparam int MAX_TASKS = 256;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 16;
	localparam int PERIOD_W  = 16;
	localparam int TIME_W    = 48;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_OVF   = 2'd3
	} pts_status_t;

	// Input modes.
	typedef enum logic {
		MODE_REGISTER = 1'b0,
		MODE_SERVICE  = 1'b1
	} pts_mode_t;

	// Kind of operation travelling down the chain.
	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_REPLACE = 1'b1
	} pts_op_t;

	// One task entry. The slot is the insertion order and breaks ties
	// between entries with equal due time and id.
	typedef struct packed {
		logic [TIME_W-1:0]   due;
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
		logic [SLOT_W-1:0]   slot;
	} pts_entry_t;

	// An operation in flight at one cell.
	typedef struct packed {
		logic       valid;
		pts_op_t    op;
		pts_entry_t entry;
	} pts_carry_t;

	// True if entry a fires before entry b.
	function automatic logic pts_earlier(pts_entry_t a, pts_entry_t b);
		return {a.due, a.id, a.slot} < {b.due, b.id, b.slot};
	endfunction

endpackage

[rtl/pts_if.sv]
// ----------------------------------------------------------------------------
// pts_if
// Request and response channels of the periodic task scheduler.
// ----------------------------------------------------------------------------
interface pts_req_if;
	import pts_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [ID_W-1:0]     task_id;
	logic [PERIOD_W-1:0] task_period;

	modport source (output valid, output mode, output task_id, output task_period,
		input ready);
	modport sink (input valid, input mode, input task_id, input task_period,
		output ready);
endinterface

interface pts_rsp_if;
	import pts_pkg::*;

	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   served_id;
	logic [TIME_W-1:0] served_time;
	logic [1:0]        status;

	modport source (output valid, output served_id, output served_time, output status,
		input ready);
	modport sink (input valid, input served_id, input served_time, input status,
		output ready);
endinterface

[rtl/pts_cell.sv]
// ----------------------------------------------------------------------------
// pts_cell
// One cell of the sorted queue: holds one entry and moves an operation on.
// ----------------------------------------------------------------------------
module pts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::pts_carry_t carry_in,
	input  pts_pkg::pts_entry_t nxt_ent,
	input  logic               nxt_vld,
	output pts_pkg::pts_entry_t ent,
	output logic               vld,
	output pts_pkg::pts_carry_t carry_out
);
	import pts_pkg::*;

	logic       carry_vld_q;
	pts_op_t    carry_op_q;
	pts_entry_t carry_ent_q;
	pts_entry_t ent_q;
	pts_entry_t ent_d;
	logic       vld_q;
	logic       vld_d;

	// An insert fills an empty cell, else keeps the lesser entry and passes
	// the larger on. A replace fills this cell's hole with the smaller of its
	// entry and the next cell's entry, moving the hole down when needed.
	always_comb begin
		ent_d     = ent_q;
		vld_d     = vld_q;
		carry_out = '0;
		if (carry_vld_q) begin
			unique case (carry_op_q)
				OP_INSERT: begin
					if (!vld_q) begin
						ent_d = carry_ent_q;
						vld_d = 1'b1;
					end else if (pts_earlier(carry_ent_q, ent_q)) begin
						ent_d           = carry_ent_q;
						carry_out.valid = 1'b1;
						carry_out.op    = OP_INSERT;
						carry_out.entry = ent_q;
					end else begin
						carry_out.valid = 1'b1;
						carry_out.op    = OP_INSERT;
						carry_out.entry = carry_ent_q;
					end
				end
				OP_REPLACE: begin
					if (nxt_vld && pts_earlier(nxt_ent, carry_ent_q)) begin
						ent_d           = nxt_ent;
						carry_out.valid = 1'b1;
						carry_out.op    = OP_REPLACE;
						carry_out.entry = carry_ent_q;
					end else begin
						ent_d = carry_ent_q;
					end
				end
				default: begin
					ent_d = ent_q;
				end
			endcase
		end
	end

	// Control state: occupancy and the operation at this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= 1'b0;
			carry_vld_q <= 1'b0;
		end else begin
			vld_q       <= vld_d;
			carry_vld_q <= carry_in.valid;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		ent_q       <= ent_d;
		carry_op_q  <= carry_in.op;
		carry_ent_q <= carry_in.entry;
	end

	assign ent = ent_q;
	assign vld = vld_q;

endmodule

[rtl/pts_chain.sv]
// ----------------------------------------------------------------------------
// pts_chain
// Row of queue cells, kept sorted with the earliest entry in the first cell.
// ----------------------------------------------------------------------------
module pts_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::pts_carry_t inject,
	output pts_pkg::pts_entry_t head,
	output logic               head_vld,
	output logic               overrun
);
	import pts_pkg::*;

	pts_carry_t carry [MAX_TASKS+1];
	pts_entry_t ent   [MAX_TASKS];
	logic       vld   [MAX_TASKS];

	assign carry[0] = inject;

	// Each cell sees the entry of the cell below it.
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		pts_entry_t nxt_ent;
		logic       nxt_vld;

		if (i == MAX_TASKS - 1) begin : g_last
			assign nxt_ent = '0;
			assign nxt_vld = 1'b0;
		end else begin : g_mid
			assign nxt_ent = ent[i+1];
			assign nxt_vld = vld[i+1];
		end

		pts_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.carry_in  (carry[i]),
			.nxt_ent   (nxt_ent),
			.nxt_vld   (nxt_vld),
			.ent       (ent[i]),
			.vld       (vld[i]),
			.carry_out (carry[i+1])
		);
	end

	assign head     = ent[0];
	assign head_vld = vld[0];

	// An operation falling off the end would lose an entry.
	assign overrun = carry[MAX_TASKS].valid;

endmodule

[rtl/periodic_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit
// A result is registered and becomes valid in the cycle after its request
// beat is accepted. Each operation moves down the cell chain one cell per
// cycle; a new request may enter while earlier ones still move down, once
// the first cell and its neighbor have settled and the output has room.
// Reset clears the task count, cell occupancy and all in-flight operations.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_unit_macros.svh"

module periodic_task_scheduler_unit (
	input  logic clk,
	input  logic arst_n,
	pts_req_if.sink   req,
	pts_rsp_if.source rsp
);
	import pts_pkg::*;

	logic                 accept;
	logic                 hold_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 full;
	logic                 empty;
	logic                 is_service;
	logic [TIME_W:0]      next_due;
	logic                 ovf;
	pts_entry_t           head;
	logic                 head_vld;
	logic                 overrun;
	pts_carry_t           inject;

	logic                 out_vld_q;
	logic [ID_W-1:0]      out_id_q;
	logic [TIME_W-1:0]    out_time_q;
	pts_status_t          out_status_q;

	// Handshake: idle while hold_q is set after a beat, and room in the output.
	assign req.ready = !hold_q && (!out_vld_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign full       = (count_q == COUNT_W'(MAX_TASKS));
	assign empty      = (count_q == '0);
	assign is_service = (req.mode == MODE_SERVICE);

	// Next due time of the head task, with a carry bit for saturation.
	assign next_due = {1'b0, head.due} + (TIME_W+1)'(head.period);
	assign ovf      = next_due[TIME_W];

	// Operation handed to the first cell.
	always_comb begin
		inject = '0;
		if (accept) begin
			if (!is_service) begin
				if (!full) begin
					inject.valid        = 1'b1;
					inject.op           = OP_INSERT;
					inject.entry.due    = TIME_W'(req.task_period);
					inject.entry.id     = req.task_id;
					inject.entry.period = req.task_period;
					inject.entry.slot   = count_q[SLOT_W-1:0];
				end
			end else if (!empty) begin
				inject.valid     = 1'b1;
				inject.op        = OP_REPLACE;
				inject.entry     = head;
				inject.entry.due = ovf ? TIME_MAX : next_due[TIME_W-1:0];
			end
		end
	end

	pts_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.inject   (inject),
		.head     (head),
		.head_vld (head_vld),
		.overrun  (overrun)
	);

	// Control state: spacing, task count and output occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= 1'b0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			hold_q <= accept;
			if (accept && !is_service && !full) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (accept) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!is_service) begin
				out_id_q     <= '0;
				out_time_q   <= '0;
				out_status_q <= full ? ST_FULL : ST_OK;
			end else if (empty) begin
				out_id_q     <= '0;
				out_time_q   <= '0;
				out_status_q <= ST_EMPTY;
			end else begin
				out_id_q     <= head.id;
				out_time_q   <= head.due;
				out_status_q <= ovf ? ST_OVF : ST_OK;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.served_id   = out_id_q;
	assign rsp.served_time = out_time_q;
	assign rsp.status      = out_status_q;

	// No operation ever runs past the last cell.
	`PTS_ASSERT_NEVER(a_no_overrun, clk, arst_n, overrun, "operation ran off the chain")

	// Once settled, the first cell holds an entry exactly when tasks exist.
	`PTS_ASSERT_IMPLY(a_head_matches_count, clk, arst_n, !hold_q,
		head_vld == (count_q != '0), "head occupancy disagrees with task count")

	// The task count never exceeds the table size.
	`PTS_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > COUNT_W'(MAX_TASKS),
		"task count beyond table size")

endmodule

[sim/periodic_task_scheduler_unit_checker.sv]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit_checker
// Watches the request and response channels of the scheduler. Each accepted
// request beat is run through a behavioral copy of the task table, and the
// predicted result is queued. Each accepted response beat is compared field
// by field against the oldest queued result.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit_checker
	import pts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pts_req_if   req,
	pts_rsp_if   rsp,
	output int   mismatch_count,
	output int   results_pending
);

	typedef struct packed {
		logic [ID_W-1:0]   served_id;
		logic [TIME_W-1:0] served_time;
		pts_status_t       status;
	} sched_result_t;

	// Behavioral copy of the task table, kept in insertion order.
	logic [ID_W-1:0]     table_ids     [MAX_TASKS];
	logic [PERIOD_W-1:0] table_periods [MAX_TASKS];
	logic [TIME_W-1:0]   table_due     [MAX_TASKS];
	int                  table_count;

	sched_result_t scheduled_results [$];

	// Applies one request to the table copy and returns the result it gives.
	function automatic sched_result_t apply_request(pts_mode_t mode,
		logic [ID_W-1:0] id, logic [PERIOD_W-1:0] period);
		sched_result_t    res;
		int               best;
		logic [TIME_W:0]  next_due;
		res.served_id   = '0;
		res.served_time = '0;
		res.status      = ST_OK;
		if (mode == MODE_REGISTER) begin
			if (table_count >= MAX_TASKS) begin
				res.status = ST_FULL;
			end else begin
				// A new task first falls due one period from time zero.
				table_ids[table_count]     = id;
				table_periods[table_count] = period;
				table_due[table_count]     = TIME_W'(period);
				table_count++;
			end
			return res;
		end
		if (table_count == 0) begin
			res.status = ST_EMPTY;
			return res;
		end
		// Earliest due time wins, then the lower id, then the older slot.
		best = 0;
		for (int i = 1; i < table_count; i++) begin
			if (table_due[i] < table_due[best] ||
				(table_due[i] == table_due[best] && table_ids[i] < table_ids[best])) begin
				best = i;
			end
		end
		res.served_id   = table_ids[best];
		res.served_time = table_due[best];
		// The rescheduled due time saturates at the top of the time range.
		next_due = {1'b0, table_due[best]} + (TIME_W + 1)'(table_periods[best]);
		if (next_due > {1'b0, TIME_MAX}) begin
			table_due[best] = TIME_MAX;
			res.status      = ST_OVF;
		end else begin
			table_due[best] = next_due[TIME_W-1:0];
		end
		return res;
	endfunction

	// Response beats are checked before request beats are queued, so that a
	// stray result is never matched against a request of the same edge.
	always @(posedge clk) begin
		sched_result_t want;
		if (!arst_n) begin
			table_count = 0;
			scheduled_results.delete();
			mismatch_count  = 0;
			results_pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (scheduled_results.size() == 0) begin
					$error("result beat with no pending request: served_id %0h", rsp.served_id);
					mismatch_count++;
				end else begin
					want = scheduled_results.pop_front();
					if (rsp.served_id !== want.served_id) begin
						$error("served_id: expected %0h, got %0h", want.served_id, rsp.served_id);
						mismatch_count++;
					end
					if (rsp.served_time !== want.served_time) begin
						$error("served_time: expected %0h, got %0h",
							want.served_time, rsp.served_time);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				scheduled_results.push_back(apply_request(pts_mode_t'(req.mode),
					req.task_id, req.task_period));
			end
			results_pending = scheduled_results.size();
		end
	end

endmodule

[sim/periodic_task_scheduler_unit_test.sv]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit_test
// Drives register and service requests into the scheduler: a directed opening
// for the empty table, extreme ids and periods and due time ties, then random
// traffic under three idling profiles that fills the table up to one free
// slot, and a closing part with a zero period task and registers into a full table.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit_test;
	import pts_pkg::*;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   results_pending;
	int   sender_gap_pct   = 12;
	int   receiver_gap_pct = 46;
	int   tasks_held       = 0;

	pts_req_if req ();
	pts_rsp_if rsp ();

	periodic_task_scheduler_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	periodic_task_scheduler_unit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Free running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Receiver stalls at random according to the current profile.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(99) >= receiver_gap_pct);
		end
	end

	// Sends one request beat, after random idle cycles, and waits for acceptance.
	task automatic send_beat(input pts_mode_t mode, input logic [ID_W-1:0] id,
		input logic [PERIOD_W-1:0] period);
		while ($urandom_range(99) < sender_gap_pct) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid       <= 1'b1;
		req.mode        <= mode;
		req.task_id     <= id;
		req.task_period <= period;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (mode == MODE_REGISTER && tasks_held < MAX_TASKS) begin
			tasks_held++;
		end
	endtask

	// Holds the request channel idle until every result has been returned.
	task automatic drain_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
	endtask

	// Ids come often from a small pool so that due time ties hit the id compare.
	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(2) == 0) begin
			return ID_W'($urandom_range(15));
		end
		return ID_W'($urandom);
	endfunction

	// Mostly short periods keep due times close together.
	function automatic logic [PERIOD_W-1:0] pick_period();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) begin
			return PERIOD_W'($urandom_range(32, 1));
		end else if (pick < 9) begin
			return PERIOD_W'($urandom_range(1024, 1));
		end
		return PERIOD_W'($urandom_range(65535, 1));
	endfunction

	// Random mix of registers and services; one slot is kept free for the
	// closing part.
	task automatic run_random(input int beats);
		for (int n = 0; n < beats; n++) begin
			if (tasks_held < MAX_TASKS - 1 && $urandom_range(99) < 55) begin
				send_beat(MODE_REGISTER, pick_id(), pick_period());
			end else begin
				send_beat(MODE_SERVICE, ID_W'($urandom), PERIOD_W'($urandom));
			end
			if ($urandom_range(49) == 0) begin
				drain_results();
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.mode        = MODE_REGISTER;
		req.task_id     = '0;
		req.task_period = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty table, extremes and due time ties.
		send_beat(MODE_SERVICE, 16'hFFFF, 16'hFFFF);
		send_beat(MODE_REGISTER, 16'h0000, 16'h0001);
		send_beat(MODE_REGISTER, 16'hFFFF, 16'hFFFF);
		send_beat(MODE_REGISTER, 16'h0005, 16'h0003);
		send_beat(MODE_REGISTER, 16'h0005, 16'h0003);
		send_beat(MODE_REGISTER, 16'h0004, 16'h0003);
		send_beat(MODE_REGISTER, 16'hAAAA, 16'h5555);
		send_beat(MODE_REGISTER, 16'h5555, 16'hAAAA);
		for (int n = 0; n < 12; n++) begin
			send_beat(MODE_SERVICE, ID_W'(n), '0);
		end

		// Random traffic under three idling profiles.
		run_random(210);
		sender_gap_pct   = 46;
		receiver_gap_pct = 12;
		run_random(210);
		sender_gap_pct   = 0;
		receiver_gap_pct = 0;
		run_random(210);

		// Closing part: fill to one short of full, add a zero period task,
		// which then wins every service, and register into the full table.
		drain_results();
		while (tasks_held < MAX_TASKS - 1) begin
			send_beat(MODE_REGISTER, pick_id(), pick_period());
		end
		send_beat(MODE_REGISTER, 16'h1234, 16'h0000);
		repeat (3) send_beat(MODE_SERVICE, ID_W'($urandom), PERIOD_W'($urandom));
		repeat (2) send_beat(MODE_REGISTER, pick_id(), pick_period());
		send_beat(MODE_SERVICE, ID_W'($urandom), PERIOD_W'($urandom));

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_if.sv
rtl/pts_cell.sv
rtl/pts_chain.sv
rtl/periodic_task_scheduler_unit.sv
sim/periodic_task_scheduler_unit_checker.sv
sim/periodic_task_scheduler_unit_test.sv
